// ----- src/bsg_pkg.sv -----
// ----------------------------------------------------------------------------
// bsg_pkg
// Shared constants, types and lookup tables for the battery gauge block.
// ----------------------------------------------------------------------------
package bsg_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int MV_W        = 16;
  localparam int PCT_W       = 7;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam int DIV_W       = 28;
  localparam int DIVISOR_W   = 12;
  localparam int CNT_W       = 5;
  localparam int RND_NUM_W   = 17;
  localparam int PCT_NUM_W   = 14;

  localparam logic [CNT_W-1:0] ITER_CAL = CNT_W'(DIV_W);
  localparam logic [CNT_W-1:0] ITER_RND = CNT_W'(RND_NUM_W);
  localparam logic [CNT_W-1:0] ITER_PCT = CNT_W'(PCT_NUM_W);

  localparam logic [SAMPLE_BITS-1:0] ZERO_OFFSET = SAMPLE_BITS'(1536);
  localparam logic [DIV_W-1:0]       HALF_STEP   = DIV_W'(256);
  localparam int                     STEP_SHIFT  = 9;
  localparam logic [MV_W-1:0]        LOW_SET_MV   = MV_W'(3400);
  localparam logic [MV_W-1:0]        LOW_CLEAR_MV = MV_W'(3550);
  localparam logic [MV_W-1:0]        GAUGE_TOP_MV = MV_W'(4200);
  localparam logic [MV_W-1:0]        GAUGE_BOT_MV = MV_W'(3000);
  localparam logic [PCT_W-1:0]       PCT_FULL     = PCT_W'(100);
  localparam logic [1:0]             DEC_NONE     = 2'd3;

  typedef enum logic [2:0] {
    REG_REF_MV     = 3'd0,
    REG_DIV_RATIO  = 3'd1,
    REG_CAL_A_SMP  = 3'd2,
    REG_CAL_A_MV   = 3'd3,
    REG_CAL_B_SMP  = 3'd4,
    REG_CAL_B_MV   = 3'd5,
    REG_DEC_PLACES = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [MV_W-1:0]        ref_mv;
    logic [4:0]             div_ratio;
    logic [SAMPLE_BITS-1:0] cal_a_smp;
    logic [MV_W-1:0]        cal_a_mv;
    logic [SAMPLE_BITS-1:0] cal_b_smp;
    logic [MV_W-1:0]        cal_b_mv;
    logic [1:0]             dec_places;
  } cfg_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ZERO,
    CMD_UNCAL_MUL,
    CMD_UNCAL_SCALE,
    CMD_CAL_MUL,
    CMD_CAL_DIV,
    CMD_CAL_SUM,
    CMD_RND_DIV,
    CMD_RND_MUL,
    CMD_PCT_FLAT,
    CMD_PCT_DIV,
    CMD_PCT_SUM,
    CMD_FINISH
  } cmd_op_t;

  typedef struct packed {
    logic below_offset;
    logic cal_equal;
    logic round_skip;
    logic pct_flat;
    logic div_busy;
    logic out_free;
  } status_t;

  function automatic logic [12:0] gauge_mv(input logic [2:0] idx);
    logic [12:0] v;
    case (idx)
      3'd0:    v = 13'd4200;
      3'd1:    v = 13'd4100;
      3'd2:    v = 13'd3900;
      3'd3:    v = 13'd3750;
      3'd4:    v = 13'd3700;
      3'd5:    v = 13'd3550;
      3'd6:    v = 13'd3450;
      default: v = 13'd3000;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] gauge_pct(input logic [2:0] idx);
    logic [PCT_W-1:0] v;
    case (idx)
      3'd0:    v = 7'd100;
      3'd1:    v = 7'd90;
      3'd2:    v = 7'd75;
      3'd3:    v = 7'd50;
      3'd4:    v = 7'd25;
      3'd5:    v = 7'd10;
      3'd6:    v = 7'd5;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  function automatic logic [9:0] round_step(input logic [1:0] dp);
    logic [9:0] v;
    case (dp)
      2'd0:    v = 10'd1000;
      2'd1:    v = 10'd100;
      2'd2:    v = 10'd10;
      default: v = 10'd1;
    endcase
    return v;
  endfunction

endpackage

// ----- src/bsg_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bsg_cfg_regs
// APB register file holding the conversion and rounding settings.
// ----------------------------------------------------------------------------
module bsg_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsg_pkg::ADDR_W-1:0]  paddr,
  input  logic [bsg_pkg::DATA_W-1:0]  pwdata,
  output logic [bsg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bsg_pkg::cfg_t               cfg
);

  bsg_pkg::cfg_t  cfg_r;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[bsg_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ref_mv     <= 16'd1050;
      cfg_r.div_ratio  <= 5'd1;
      cfg_r.cal_a_smp  <= '0;
      cfg_r.cal_a_mv   <= '0;
      cfg_r.cal_b_smp  <= '0;
      cfg_r.cal_b_mv   <= '0;
      cfg_r.dec_places <= 2'd2;
    end else if (wr_en) begin
      case (idx)
        bsg_pkg::REG_REF_MV:     cfg_r.ref_mv     <= pwdata[15:0];
        bsg_pkg::REG_DIV_RATIO:  cfg_r.div_ratio  <= pwdata[4:0];
        bsg_pkg::REG_CAL_A_SMP:  cfg_r.cal_a_smp  <= pwdata[11:0];
        bsg_pkg::REG_CAL_A_MV:   cfg_r.cal_a_mv   <= pwdata[15:0];
        bsg_pkg::REG_CAL_B_SMP:  cfg_r.cal_b_smp  <= pwdata[11:0];
        bsg_pkg::REG_CAL_B_MV:   cfg_r.cal_b_mv   <= pwdata[15:0];
        bsg_pkg::REG_DEC_PLACES: cfg_r.dec_places <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bsg_pkg::REG_REF_MV:     prdata = 32'(cfg_r.ref_mv);
      bsg_pkg::REG_DIV_RATIO:  prdata = 32'(cfg_r.div_ratio);
      bsg_pkg::REG_CAL_A_SMP:  prdata = 32'(cfg_r.cal_a_smp);
      bsg_pkg::REG_CAL_A_MV:   prdata = 32'(cfg_r.cal_a_mv);
      bsg_pkg::REG_CAL_B_SMP:  prdata = 32'(cfg_r.cal_b_smp);
      bsg_pkg::REG_CAL_B_MV:   prdata = 32'(cfg_r.cal_b_mv);
      bsg_pkg::REG_DEC_PLACES: prdata = 32'(cfg_r.dec_places);
      default:                 prdata = '0;
    endcase
  end

endmodule

// ----- src/bsg_div.sv -----
// ----------------------------------------------------------------------------
// bsg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [bsg_pkg::DIV_W-1:0]      dividend,
  input  logic [bsg_pkg::DIVISOR_W-1:0]  divisor,
  input  logic [bsg_pkg::CNT_W-1:0]      iters,
  output logic                           busy,
  output logic [bsg_pkg::DIV_W-1:0]      quotient
);

  logic [bsg_pkg::CNT_W-1:0]      cnt_r;
  logic [bsg_pkg::DIV_W-1:0]      q_r;
  logic [bsg_pkg::DIVISOR_W-1:0]  rem_r;
  logic [bsg_pkg::DIVISOR_W-1:0]  dvs_r;
  logic [bsg_pkg::DIVISOR_W:0]    rem_sh;
  logic [bsg_pkg::DIVISOR_W:0]    rem_sub;
  logic                           ge;
  logic [bsg_pkg::DIVISOR_W-1:0]  rem_nxt;

  // dividend is left aligned, so after iters steps q_r holds the quotient
  assign rem_sh   = {rem_r, q_r[bsg_pkg::DIV_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs_r};
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign rem_nxt  = ge ? rem_sub[bsg_pkg::DIVISOR_W-1:0] : rem_sh[bsg_pkg::DIVISOR_W-1:0];
  assign busy     = cnt_r != '0;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= iters;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy) begin
      q_r   <= {q_r[bsg_pkg::DIV_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

endmodule

// ----- src/bsg_datapath.sv -----
// ----------------------------------------------------------------------------
// bsg_datapath
// Conversion, rounding, interpolation and result registers.
// ----------------------------------------------------------------------------
module bsg_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bsg_pkg::cfg_t                    cfg,
  input  bsg_pkg::cmd_op_t                 op,
  output bsg_pkg::status_t                 sts,
  input  logic [bsg_pkg::SAMPLE_BITS-1:0]  in_raw_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bsg_pkg::MV_W-1:0]         out_millivolts,
  output logic [bsg_pkg::PCT_W-1:0]        out_percent,
  output logic                             out_low_batt
);

  logic [bsg_pkg::SAMPLE_BITS-1:0]  s_r;
  logic [bsg_pkg::DIV_W-1:0]        acc_r;
  logic                             neg_r;
  logic [bsg_pkg::MV_W-1:0]         mv_r;
  logic [bsg_pkg::PCT_W-1:0]        pct_base_r;
  logic [bsg_pkg::PCT_W-1:0]        pct_r;
  logic                             low_flag_r;
  logic                             out_valid_r;
  logic [bsg_pkg::MV_W-1:0]         out_mv_r;
  logic [bsg_pkg::PCT_W-1:0]        out_pct_r;
  logic                             out_low_r;

  logic                             div_start;
  logic [bsg_pkg::DIV_W-1:0]        div_dividend;
  logic [bsg_pkg::DIVISOR_W-1:0]    div_divisor;
  logic [bsg_pkg::CNT_W-1:0]        div_iters;
  logic                             div_busy;
  logic [bsg_pkg::DIV_W-1:0]        quot;

  // uncalibrated path
  logic [bsg_pkg::SAMPLE_BITS-1:0]  s_off;
  logic [bsg_pkg::DIV_W-1:0]        uncal_prod;
  logic [bsg_pkg::DIV_W-1:0]        uncal_sum;
  logic [bsg_pkg::MV_W-1:0]         uncal_t;
  logic [31:0]                      uncal_scaled;

  // calibrated path
  logic [12:0]                      ds;
  logic [16:0]                      dm;
  logic [12:0]                      den;
  logic [12:0]                      ds_neg;
  logic [16:0]                      dm_neg;
  logic [12:0]                      den_neg;
  logic [11:0]                      ds_mag;
  logic [15:0]                      dm_mag;
  logic [11:0]                      den_mag;
  logic [bsg_pkg::DIV_W-1:0]        cal_prod;
  logic [bsg_pkg::MV_W-1:0]         cal_q;
  logic [bsg_pkg::MV_W-1:0]         cal_mv;

  // rounding
  logic [9:0]                       step;
  logic [bsg_pkg::RND_NUM_W-1:0]    rnd_num;
  logic [22:0]                      rnd_prod;

  // interpolation
  logic [2:0]                       seg;
  logic [2:0]                       seg_lo;
  logic [12:0]                      g_hi;
  logic [12:0]                      g_lo;
  logic [12:0]                      g_span;
  logic [bsg_pkg::MV_W-1:0]         mv_rel;
  logic [bsg_pkg::PCT_W-1:0]        p_diff;
  logic [bsg_pkg::PCT_NUM_W-1:0]    pct_num;

  logic                             low_nxt;

  bsg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .iters    (div_iters),
    .busy     (div_busy),
    .quotient (quot)
  );

  assign s_off        = s_r - bsg_pkg::ZERO_OFFSET;
  assign uncal_prod   = {{(bsg_pkg::DIV_W-12){1'b0}}, s_off} * {12'd0, cfg.ref_mv};
  assign uncal_sum    = acc_r + bsg_pkg::HALF_STEP;
  assign uncal_t      = uncal_sum[bsg_pkg::STEP_SHIFT +: bsg_pkg::MV_W];
  assign uncal_scaled = {16'd0, uncal_t} * {27'd0, cfg.div_ratio};

  assign ds       = {1'b0, s_r} - {1'b0, cfg.cal_a_smp};
  assign dm       = {1'b0, cfg.cal_b_mv} - {1'b0, cfg.cal_a_mv};
  assign den      = {1'b0, cfg.cal_b_smp} - {1'b0, cfg.cal_a_smp};
  assign ds_neg   = 13'd0 - ds;
  assign dm_neg   = 17'd0 - dm;
  assign den_neg  = 13'd0 - den;
  assign ds_mag   = ds[12]  ? ds_neg[11:0]  : ds[11:0];
  assign dm_mag   = dm[16]  ? dm_neg[15:0]  : dm[15:0];
  assign den_mag  = den[12] ? den_neg[11:0] : den[11:0];
  assign cal_prod = {16'd0, ds_mag} * {12'd0, dm_mag};
  assign cal_q    = neg_r ? (16'd0 - quot[15:0]) : quot[15:0];
  assign cal_mv   = cfg.cal_a_mv + cal_q;

  assign step     = bsg_pkg::round_step(cfg.dec_places);
  assign rnd_num  = {1'b0, mv_r} + {8'd0, step[9:1]};
  assign rnd_prod = {10'd0, quot[12:0]} * {13'd0, step};

  always_comb begin
    seg = '0;
    for (int k = 1; k < 8; k++) begin
      seg = seg + {2'b00, mv_r <= {3'b000, bsg_pkg::gauge_mv(3'(k))}};
    end
  end

  assign seg_lo  = seg + 3'd1;
  assign g_hi    = bsg_pkg::gauge_mv(seg);
  assign g_lo    = bsg_pkg::gauge_mv(seg_lo);
  assign g_span  = g_hi - g_lo;
  assign mv_rel  = mv_r - {3'b000, g_lo};
  assign p_diff  = bsg_pkg::gauge_pct(seg) - bsg_pkg::gauge_pct(seg_lo);
  assign pct_num = {5'd0, mv_rel[8:0]} * {9'd0, p_diff[4:0]};

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_iters    = '0;
    case (op)
      bsg_pkg::CMD_CAL_DIV: begin
        div_start    = 1'b1;
        div_dividend = acc_r;
        div_divisor  = den_mag;
        div_iters    = bsg_pkg::ITER_CAL;
      end
      bsg_pkg::CMD_RND_DIV: begin
        div_start    = 1'b1;
        div_dividend = {rnd_num, {(bsg_pkg::DIV_W-bsg_pkg::RND_NUM_W){1'b0}}};
        div_divisor  = {2'b00, step};
        div_iters    = bsg_pkg::ITER_RND;
      end
      bsg_pkg::CMD_PCT_DIV: begin
        div_start    = 1'b1;
        div_dividend = {pct_num, {(bsg_pkg::DIV_W-bsg_pkg::PCT_NUM_W){1'b0}}};
        div_divisor  = g_span[11:0];
        div_iters    = bsg_pkg::ITER_PCT;
      end
      default: ;
    endcase
  end

  assign low_nxt = low_flag_r ? (mv_r < bsg_pkg::LOW_CLEAR_MV)
                              : (mv_r <= bsg_pkg::LOW_SET_MV);

  always_ff @(posedge clk) begin
    case (op)
      bsg_pkg::CMD_LOAD:        s_r <= in_raw_sample;
      bsg_pkg::CMD_ZERO:        mv_r <= '0;
      bsg_pkg::CMD_UNCAL_MUL:   acc_r <= uncal_prod;
      bsg_pkg::CMD_UNCAL_SCALE: mv_r <= uncal_scaled[15:0];
      bsg_pkg::CMD_CAL_MUL: begin
        acc_r <= cal_prod;
        neg_r <= ds[12] ^ dm[16] ^ den[12];
      end
      bsg_pkg::CMD_CAL_SUM:     mv_r <= cal_mv;
      bsg_pkg::CMD_RND_MUL:     mv_r <= rnd_prod[15:0];
      bsg_pkg::CMD_PCT_FLAT:
        pct_r <= (mv_r >= bsg_pkg::GAUGE_TOP_MV) ? bsg_pkg::PCT_FULL : '0;
      bsg_pkg::CMD_PCT_DIV:     pct_base_r <= bsg_pkg::gauge_pct(seg_lo);
      bsg_pkg::CMD_PCT_SUM:     pct_r <= pct_base_r + quot[6:0];
      bsg_pkg::CMD_FINISH: begin
        out_mv_r  <= mv_r;
        out_pct_r <= pct_r;
        out_low_r <= low_nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_flag_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (op == bsg_pkg::CMD_FINISH) begin
      low_flag_r  <= low_nxt;
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.below_offset = s_r <= bsg_pkg::ZERO_OFFSET;
  assign sts.cal_equal    = cfg.cal_a_smp == cfg.cal_b_smp;
  assign sts.round_skip   = cfg.dec_places == bsg_pkg::DEC_NONE;
  assign sts.pct_flat     = (mv_r >= bsg_pkg::GAUGE_TOP_MV) || (mv_r <= bsg_pkg::GAUGE_BOT_MV);
  assign sts.div_busy     = div_busy;
  assign sts.out_free     = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_millivolts = out_mv_r;
  assign out_percent    = out_pct_r;
  assign out_low_batt   = out_low_r;

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_finish_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (op == bsg_pkg::CMD_FINISH) |-> (!out_valid_r || !out_stall))
    else $error("result overwritten before taken");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(op == bsg_pkg::CMD_FINISH))
    else $error("result raised without finish");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pct_r <= bsg_pkg::PCT_FULL))
    else $error("percent out of range");

endmodule

// ----- src/bsg_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsg_ctrl
// Sequencer stepping the datapath through conversion, rounding and gauge.
// ----------------------------------------------------------------------------
module bsg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bsg_pkg::status_t   sts,
  output bsg_pkg::cmd_op_t   op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASSIFY,
    S_UNCAL_SCALE,
    S_CAL_DIV,
    S_CAL_WAIT,
    S_ROUND,
    S_RND_WAIT,
    S_PCT,
    S_PCT_WAIT,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    op        = bsg_pkg::CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = bsg_pkg::CMD_LOAD;
          state_nxt = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (sts.below_offset) begin
          op        = bsg_pkg::CMD_ZERO;
          state_nxt = S_PCT;
        end else if (sts.cal_equal) begin
          op        = bsg_pkg::CMD_UNCAL_MUL;
          state_nxt = S_UNCAL_SCALE;
        end else begin
          op        = bsg_pkg::CMD_CAL_MUL;
          state_nxt = S_CAL_DIV;
        end
      end
      S_UNCAL_SCALE: begin
        op        = bsg_pkg::CMD_UNCAL_SCALE;
        state_nxt = S_ROUND;
      end
      S_CAL_DIV: begin
        op        = bsg_pkg::CMD_CAL_DIV;
        state_nxt = S_CAL_WAIT;
      end
      S_CAL_WAIT: begin
        if (!sts.div_busy) begin
          op        = bsg_pkg::CMD_CAL_SUM;
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        if (sts.round_skip) begin
          state_nxt = S_PCT;
        end else begin
          op        = bsg_pkg::CMD_RND_DIV;
          state_nxt = S_RND_WAIT;
        end
      end
      S_RND_WAIT: begin
        if (!sts.div_busy) begin
          op        = bsg_pkg::CMD_RND_MUL;
          state_nxt = S_PCT;
        end
      end
      S_PCT: begin
        if (sts.pct_flat) begin
          op        = bsg_pkg::CMD_PCT_FLAT;
          state_nxt = S_FINISH;
        end else begin
          op        = bsg_pkg::CMD_PCT_DIV;
          state_nxt = S_PCT_WAIT;
        end
      end
      S_PCT_WAIT: begin
        if (!sts.div_busy) begin
          op        = bsg_pkg::CMD_PCT_SUM;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          op        = bsg_pkg::CMD_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/battery_sample_to_gauge.sv -----
// ----------------------------------------------------------------------------
// battery_sample_to_gauge
// Raw ADC sample to rounded millivolts, charge percent and low flag.
// ----------------------------------------------------------------------------
//  channel | ports                                        | beat
//  --------+----------------------------------------------+----------------------
//  in      | in_valid, in_stall, in_raw_sample            | one 12-bit sample
//  out     | out_valid, out_stall, out_millivolts,        | one gauge result
//          | out_percent, out_low_batt                    |
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata | one 32-bit register
//
//  One sample at a time. The shared restoring divider (one quotient bit per
//  cycle; 28, 17 and 14 quotient bits) serves calibration, rounding and
//  the percent step.
//  A finished result sits in the output register; the next sample is taken
//  while it waits. Sync reset restores register defaults and clears the flag.
// ----------------------------------------------------------------------------
module battery_sample_to_gauge (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bsg_pkg::SAMPLE_BITS-1:0]  in_raw_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bsg_pkg::MV_W-1:0]         out_millivolts,
  output logic [bsg_pkg::PCT_W-1:0]        out_percent,
  output logic                             out_low_batt,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bsg_pkg::ADDR_W-1:0]       paddr,
  input  logic [bsg_pkg::DATA_W-1:0]       pwdata,
  output logic [bsg_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);

  bsg_pkg::cfg_t     cfg;
  bsg_pkg::cmd_op_t  op;
  bsg_pkg::status_t  sts;

  bsg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .op       (op)
  );

  bsg_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .op             (op),
    .sts            (sts),
    .in_raw_sample  (in_raw_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_millivolts (out_millivolts),
    .out_percent    (out_percent),
    .out_low_batt   (out_low_batt)
  );

endmodule

// ----- dv/battery_sample_to_gauge_test.sv -----
// ----------------------------------------------------------------------------
// battery_sample_to_gauge_test
// Self-checking bench for the battery gauge: raw samples go in with random
// gaps, each gauge reading coming out is compared field by field against a
// local model of the voltage conversion, rounding, charge curve and
// low-battery hysteresis. Settings change over APB between phases.
// ----------------------------------------------------------------------------
module battery_sample_to_gauge_test;
  import bsg_pkg::*;

  localparam int unsigned OFFSET_SAMPLE  = 1536;
  localparam int unsigned LOW_ENTER_MV   = 3400;
  localparam int unsigned LOW_LEAVE_MV   = 3550;
  localparam int unsigned UNUSED_REG_IDX = 7;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_SAMPLES  = 115;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [PCT_W-1:0] pct;
    logic             low;
  } gauge_reading_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] in_raw_sample = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [MV_W-1:0]        out_millivolts;
  logic [PCT_W-1:0]       out_percent;
  logic                   out_low_batt;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  cfg_t           gauge_cfg;
  logic           low_latched;
  gauge_reading_t pending_readings[$];
  int unsigned    mismatches = 0;
  bit             src_burst = 1'b0;
  bit             sink_burst = 1'b0;
  bit             hold_req = 1'b0;
  int unsigned    focus_lo = 0;
  int unsigned    focus_hi = 4095;

  battery_sample_to_gauge uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_sample  (in_raw_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_millivolts (out_millivolts),
    .out_percent    (out_percent),
    .out_low_batt   (out_low_batt),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #10_000_000;
    $display("battery_sample_to_gauge: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- model
  function automatic int unsigned lerp(int unsigned mv, int unsigned lo_mv,
                                       int unsigned hi_mv, int unsigned lo_pct,
                                       int unsigned hi_pct);
    return lo_pct + (mv - lo_mv) * (hi_pct - lo_pct) / (hi_mv - lo_mv);
  endfunction

  function automatic logic [PCT_W-1:0] charge_percent(logic [MV_W-1:0] mv);
    int unsigned v;
    v = mv;
    if (v >= 4200) return PCT_W'(100);
    if (v <= 3000) return PCT_W'(0);
    if (v > 4100) return PCT_W'(lerp(v, 4100, 4200, 90, 100));
    if (v > 3900) return PCT_W'(lerp(v, 3900, 4100, 75, 90));
    if (v > 3750) return PCT_W'(lerp(v, 3750, 3900, 50, 75));
    if (v > 3700) return PCT_W'(lerp(v, 3700, 3750, 25, 50));
    if (v > 3550) return PCT_W'(lerp(v, 3550, 3700, 10, 25));
    if (v > 3450) return PCT_W'(lerp(v, 3450, 3550, 5, 10));
    return PCT_W'(lerp(v, 3000, 3450, 0, 5));
  endfunction

  function automatic logic [MV_W-1:0] battery_millivolts(logic [SAMPLE_BITS-1:0] s);
    longint unsigned scaled;
    longint          num;
    longint          den;
    logic [MV_W-1:0] mv;
    int unsigned     step;
    if (s <= OFFSET_SAMPLE) return '0;
    if (gauge_cfg.cal_a_smp == gauge_cfg.cal_b_smp) begin
      scaled = ((64'(s) - 64'(OFFSET_SAMPLE)) * 64'(gauge_cfg.ref_mv) + 64'd256) / 64'd512;
      mv = MV_W'(scaled * 64'(gauge_cfg.div_ratio));
    end else begin
      num = (longint'(s) - longint'(gauge_cfg.cal_a_smp)) *
            (longint'(gauge_cfg.cal_b_mv) - longint'(gauge_cfg.cal_a_mv));
      den = longint'(gauge_cfg.cal_b_smp) - longint'(gauge_cfg.cal_a_smp);
      mv = MV_W'(longint'(gauge_cfg.cal_a_mv) + num / den);
    end
    case (gauge_cfg.dec_places)
      2'd0:    step = 1000;
      2'd1:    step = 100;
      2'd2:    step = 10;
      default: return mv;
    endcase
    return MV_W'((int'(mv) + step / 2) / step * step);
  endfunction

  function automatic gauge_reading_t gauge_reading(logic [SAMPLE_BITS-1:0] s);
    gauge_reading_t r;
    r.mv = battery_millivolts(s);
    if (!low_latched && r.mv <= LOW_ENTER_MV) low_latched = 1'b1;
    else if (low_latched && r.mv >= LOW_LEAVE_MV) low_latched = 1'b0;
    r.pct = charge_percent(r.mv);
    r.low = low_latched;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_sample(logic [SAMPLE_BITS-1:0] s);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_sample <= s;
    do @(posedge clk); while (in_stall);
    pending_readings.push_back(gauge_reading(s));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(int unsigned idx, logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_REF_MV:     gauge_cfg.ref_mv = data[MV_W-1:0];
      REG_DIV_RATIO:  gauge_cfg.div_ratio = data[4:0];
      REG_CAL_A_SMP:  gauge_cfg.cal_a_smp = data[SAMPLE_BITS-1:0];
      REG_CAL_A_MV:   gauge_cfg.cal_a_mv = data[MV_W-1:0];
      REG_CAL_B_SMP:  gauge_cfg.cal_b_smp = data[SAMPLE_BITS-1:0];
      REG_CAL_B_MV:   gauge_cfg.cal_b_mv = data[MV_W-1:0];
      REG_DEC_PLACES: gauge_cfg.dec_places = data[1:0];
      default: ;
    endcase
  endtask

  // junk above the register width must be dropped
  function automatic logic [DATA_W-1:0] with_junk(int unsigned v, int unsigned w);
    return (DATA_W'($urandom) << w) | DATA_W'(v);
  endfunction

  task automatic set_calibration(int unsigned a_smp, int unsigned a_mv,
                                 int unsigned b_smp, int unsigned b_mv);
    write_reg(REG_CAL_A_SMP, with_junk(a_smp, SAMPLE_BITS));
    write_reg(REG_CAL_A_MV, with_junk(a_mv, MV_W));
    write_reg(REG_CAL_B_SMP, with_junk(b_smp, SAMPLE_BITS));
    write_reg(REG_CAL_B_MV, with_junk(b_mv, MV_W));
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    int unsigned gap;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = sink_burst ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin : reading_check
    gauge_reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected beat: millivolts %0d percent %0d low_batt %0d",
               out_millivolts, out_percent, out_low_batt);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        if (out_millivolts !== want.mv) begin
          $error("millivolts: expected %0d, got %0d", want.mv, out_millivolts);
          mismatches++;
        end
        if (out_percent !== want.pct) begin
          $error("percent: expected %0d, got %0d", want.pct, out_percent);
          mismatches++;
        end
        if (out_low_batt !== want.low) begin
          $error("low_batt: expected %0d, got %0d", want.low, out_low_batt);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // reset settings: uncalibrated, 2 decimals; offset edge and hysteresis walk
  task automatic test_defaults_and_hysteresis();
    send_sample(12'd0);
    send_sample(12'd1536);
    send_sample(12'd1537);
    send_sample(12'd4095);
    send_sample(12'd3190);
    send_sample(12'd3250);
    send_sample(12'd3270);
    send_sample(12'd3230);
    send_sample(12'd3195);
    send_sample(12'd2560);
  endtask

  task automatic test_uncalibrated_extremes();
    settle();
    write_reg(REG_REF_MV, with_junk(65535, MV_W));
    write_reg(REG_DIV_RATIO, with_junk(16, 5));
    write_reg(REG_DEC_PLACES, with_junk(3, 2));
    send_sample(12'd4095);
    send_sample(12'd1537);
    settle();
    write_reg(REG_DIV_RATIO, 32'd1);
    write_reg(REG_DEC_PLACES, 32'd0);
    send_sample(12'd2048);
    settle();
    write_reg(REG_DEC_PLACES, 32'd1);
    send_sample(12'd2048);
    settle();
    write_reg(REG_DIV_RATIO, 32'd0);
    send_sample(12'd3000);
    settle();
    write_reg(REG_DIV_RATIO, 32'd31);
    write_reg(REG_DEC_PLACES, 32'd2);
    send_sample(12'd4095);
    settle();
    write_reg(REG_REF_MV, 32'd0);
    send_sample(12'd4095);
  endtask

  task automatic test_calibrated();
    settle();
    write_reg(REG_REF_MV, 32'd1050);
    write_reg(REG_DIV_RATIO, 32'd2);
    write_reg(REG_DEC_PLACES, 32'd3);
    set_calibration(1600, 3000, 3600, 4200);
    send_sample(12'd1537);
    send_sample(12'd1600);
    send_sample(12'd2600);
    send_sample(12'd3600);
    send_sample(12'd4095);
    settle();
    // descending point order, negative denominator
    set_calibration(3600, 4200, 1600, 3000);
    send_sample(12'd2100);
    send_sample(12'd4095);
    settle();
    // result below zero wraps
    set_calibration(1600, 0, 1700, 65535);
    send_sample(12'd1537);
    send_sample(12'd4095);
  endtask

  task automatic test_unused_register();
    settle();
    write_reg(UNUSED_REG_IDX, $urandom);
    send_sample(12'd2222);
  endtask

  task automatic test_backpressure();
    int unsigned n;
    settle();
    hold_req = 1'b1;
    src_burst = 1'b1;
    for (n = 0; n < 12; n++) send_sample(12'($urandom));
    src_burst = 1'b0;
  endtask

  task automatic choose_settings(int unsigned kind);
    int unsigned ref_mv, ratio, a_smp, b_smp, a_mv, b_mv, center;
    write_reg(REG_DEC_PLACES, with_junk($urandom_range(0, 3), 2));
    if (kind == 0) begin
      ref_mv = $urandom_range(900, 1200);
      ratio = $urandom_range(1, 4);
      a_smp = $urandom_range(0, 4095);
      write_reg(REG_REF_MV, with_junk(ref_mv, MV_W));
      write_reg(REG_DIV_RATIO, with_junk(ratio, 5));
      set_calibration(a_smp, $urandom_range(0, 65535), a_smp, $urandom_range(0, 65535));
      center = OFFSET_SAMPLE + 3600 * 512 / (ref_mv * ratio);
      focus_lo = center - 300;
      focus_hi = (center + 300 > 4095) ? 4095 : center + 300;
    end else if (kind == 1) begin
      a_smp = $urandom_range(1700, 2600);
      b_smp = a_smp + $urandom_range(100, 900);
      a_mv = $urandom_range(2800, 3300);
      b_mv = $urandom_range(3900, 4400);
      if ($urandom_range(0, 1)) set_calibration(a_smp, a_mv, b_smp, b_mv);
      else set_calibration(b_smp, b_mv, a_smp, a_mv);
      focus_lo = a_smp - 150;
      focus_hi = b_smp + 150;
    end else begin
      write_reg(REG_REF_MV, $urandom);
      write_reg(REG_DIV_RATIO, $urandom);
      write_reg(REG_CAL_A_SMP, $urandom);
      write_reg(REG_CAL_A_MV, $urandom);
      write_reg(REG_CAL_B_SMP, $urandom);
      write_reg(REG_CAL_B_MV, $urandom);
      focus_lo = 0;
      focus_hi = 4095;
    end
    if ($urandom_range(0, 3) == 0) write_reg(UNUSED_REG_IDX, $urandom);
  endtask

  task automatic test_random_phases();
    int unsigned p, n;
    for (p = 0; p < 8; p++) begin
      settle();
      choose_settings(p % 3);
      src_burst = (p == 4);
      sink_burst = (p == 4) || (p == 6);
      for (n = 0; n < PHASE_SAMPLES; n++) begin
        if ($urandom_range(0, 9) < 7)
          send_sample(12'($urandom_range(focus_lo, focus_hi)));
        else
          send_sample(12'($urandom));
      end
    end
    src_burst = 1'b0;
    sink_burst = 1'b0;
  endtask

  initial begin
    gauge_cfg.ref_mv = 16'd1050;
    gauge_cfg.div_ratio = 5'd1;
    gauge_cfg.cal_a_smp = '0;
    gauge_cfg.cal_a_mv = '0;
    gauge_cfg.cal_b_smp = '0;
    gauge_cfg.cal_b_mv = '0;
    gauge_cfg.dec_places = 2'd2;
    low_latched = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults_and_hysteresis();
    test_uncalibrated_extremes();
    test_calibrated();
    test_unused_register();
    test_backpressure();
    test_random_phases();
    settle();
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("battery_sample_to_gauge: match");
    end else begin
      $display("battery_sample_to_gauge: mismatch");
    end
    $finish;
  end

endmodule

// ----- battery_sample_to_gauge.f -----
src/bsg_pkg.sv
src/bsg_cfg_regs.sv
src/bsg_div.sv
src/bsg_datapath.sv
src/bsg_ctrl.sv
src/battery_sample_to_gauge.sv
dv/battery_sample_to_gauge_test.sv
